// File: hw/rtl/ovm_pkg.sv
`timescale 1ns / 1ps

package ovm_pkg;

   localparam int TRIG_ITERATIONS_DEF = 16;

   // register indexes of the configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Z = 2'd2;

   localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
   localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
   localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;
   localparam logic [12:0]        RECIP_45     = 13'd5826; // ceil(2^18 / 45)
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
   localparam logic signed [31:0] ONE_Q16      = 32'sd65536;

   typedef struct packed {
      logic [12:0] mag;
      logic        neg;
      logic        flip;
   } angle_type;

   typedef struct packed {
      logic en;
      logic flip;
   } cordic_ctl_type;

   // fold an angle in [-half turn, half turn) into [-quarter, quarter]
   function automatic angle_type fold_angle(input logic signed [15:0] a);
      angle_type r;
      logic signed [15:0] b;
      b = a;
      r.flip = 1'b0;
      if (b > QUARTER_TURN) begin
         b = b - 16'(HALF_TURN);
         r.flip = 1'b1;
      end else if (b < -QUARTER_TURN) begin
         b = b + 16'(HALF_TURN);
         r.flip = 1'b1;
      end
      r.neg = b[15];
      r.mag = b[15] ? 13'(-b) : 13'(b);
      return r;
   endfunction

   // round(ra * 2^23 / 45) half away from zero, ra below 45
   function automatic logic [22:0] frac_lut(input logic [5:0] ra);
      logic [29:0] n;
      n = {ra, 24'd0} + 30'd45;
      return 23'(n / 30'd90);
   endfunction

   function automatic logic [31:0] atan_bam(input int i);
      logic [31:0] r;
      case (i)
         0:       r = 32'd536870912;
         1:       r = 32'd316933406;
         2:       r = 32'd167458907;
         3:       r = 32'd85004756;
         4:       r = 32'd42667331;
         5:       r = 32'd21354465;
         6:       r = 32'd10679838;
         7:       r = 32'd5340245;
         8:       r = 32'd2670163;
         9:       r = 32'd1335087;
         10:      r = 32'd667544;
         11:      r = 32'd333772;
         12:      r = 32'd166886;
         13:      r = 32'd83443;
         14:      r = 32'd41722;
         15:      r = 32'd20861;
         16:      r = 32'd10430;
         17:      r = 32'd5215;
         18:      r = 32'd2608;
         19:      r = 32'd1304;
         20:      r = 32'd652;
         21:      r = 32'd326;
         22:      r = 32'd163;
         23:      r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/ovm_cordic.sv
`timescale 1ns / 1ps

// Rotation-mode CORDIC, one iteration per stage, then a registered clamp and fold undo.
module ovm_cordic #(
   parameter int ITER = ovm_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                   clock,
   input  ovm_pkg::cordic_ctl_type ctl_i,
   input  logic signed [33:0]     z_i,
   output logic signed [31:0]     cos_o,
   output logic signed [31:0]     sin_o
);

   logic signed [33:0] xs [ITER+1];
   logic signed [33:0] ys [ITER+1];
   logic signed [33:0] zs [ITER+1];
   logic               fs [ITER+1];

   logic signed [33:0] x_ff [ITER];
   logic signed [33:0] y_ff [ITER];
   logic signed [33:0] z_ff [ITER];
   logic               f_ff [ITER];

   assign xs[0] = ovm_pkg::CORDIC_GAIN;
   assign ys[0] = '0;
   assign zs[0] = z_i;
   assign fs[0] = ctl_i.flip;

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      localparam logic signed [33:0] ATAN_I = 34'(ovm_pkg::atan_bam(i));
      logic signed [33:0] x_in, y_in, z_in;

      always_comb begin
         if (zs[i] >= 0) begin
            x_in = xs[i] - (ys[i] >>> i);
            y_in = ys[i] + (xs[i] >>> i);
            z_in = zs[i] - ATAN_I;
         end else begin
            x_in = xs[i] + (ys[i] >>> i);
            y_in = ys[i] - (xs[i] >>> i);
            z_in = zs[i] + ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_i.en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
            f_ff[i] <= fs[i];
         end
      end

      assign xs[i+1] = x_ff[i];
      assign ys[i+1] = y_ff[i];
      assign zs[i+1] = z_ff[i];
      assign fs[i+1] = f_ff[i];
   end

   logic signed [33:0] cx, cy;
   logic signed [31:0] cos_in, sin_in;

   // clamp to the unit range, then undo the half-turn fold
   always_comb begin
      cx = xs[ITER];
      cy = ys[ITER];
      if (cx > ovm_pkg::ONE_Q30)  cx = ovm_pkg::ONE_Q30;
      if (cx < -ovm_pkg::ONE_Q30) cx = -ovm_pkg::ONE_Q30;
      if (cy > ovm_pkg::ONE_Q30)  cy = ovm_pkg::ONE_Q30;
      if (cy < -ovm_pkg::ONE_Q30) cy = -ovm_pkg::ONE_Q30;
      if (fs[ITER]) begin
         cx = -cx;
         cy = -cy;
      end
      cos_in = 32'(cx);
      sin_in = 32'(cy);
   end

   always_ff @(posedge clock) begin
      if (ctl_i.en) begin
         cos_o <= cos_in;
         sin_o <= sin_in;
      end
   end

endmodule

// File: hw/rtl/orbit_view_matrix.sv
`timescale 1ns / 1ps

// Orbit camera view matrix. Each request word (yaw, pitch in 1/64 degree,
// distance in Q16.16) yields sixteen response words, the 4x4 view matrix
// Tz(-distance) * Rx(-pitch) * Ry(-yaw) * T(-target) in row-major order, with
// last set on row 3, column 3; entries are saturated Q16.16. The target point
// is written through the csr port (index 0..2 = x, y, z; other indexes are
// dropped); the user must write it only while the block is idle (unenforced).
// A request passes a pipeline of TRIG_ITERATIONS + 8 stages: three for angle
// reduction, TRIG_ITERATIONS + 1 for the two CORDIC lanes, four for the
// products and the translation column. Requests may enter every cycle while
// req_ready is high; the one-word response port bounds throughput, and a full
// matrix bank ahead of the port lets the next matrix wait at the pipeline end.
module orbit_view_matrix #(
   parameter int TRIG_ITERATIONS = ovm_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [15:0]            req_yaw_deg,
   input  logic signed [13:0]            req_pitch_deg,
   input  logic signed [31:0]            req_distance,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_row,
   output logic [1:0]                    rsp_col,
   output logic signed [31:0]            rsp_value,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [ovm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int LAT = TRIG_ITERATIONS + 1;   // CORDIC register stages
   localparam int NV  = LAT + 7;               // pipeline stages
   localparam int S4  = LAT + 2;               // CORDIC output stage
   localparam int S8  = NV - 1;                // last stage

   // ---------------- configuration
   logic signed [31:0] tgt_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff[0] <= '0;
         tgt_ff[1] <= '0;
         tgt_ff[2] <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ovm_pkg::CSR_TARGET_X: tgt_ff[0] <= csr_wdata;
            ovm_pkg::CSR_TARGET_Y: tgt_ff[1] <= csr_wdata;
            ovm_pkg::CSR_TARGET_Z: tgt_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control: one enable for the whole pipeline
   logic          adv;
   logic          load;
   logic [3:0]    idx_ff;
   logic          rsp_valid_ff;
   logic [NV-1:0] vld_ff;

   assign load      = vld_ff[S8] && (!rsp_valid_ff || (rsp_ready && idx_ff == 4'd15));
   assign adv       = !vld_ff[S8] || load;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NV-2:0], req_valid};
      end
   end

   // distance rides along to stage 7
   logic signed [31:0] dist_ff [NV-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff[0] <= req_distance;
         for (int k = 1; k < NV - 1; k++) dist_ff[k] <= dist_ff[k-1];
      end
   end

   // ---------------- stage 1: reduce yaw modulo a turn, clamp pitch, fold
   logic signed [16:0] ym;
   logic signed [15:0] pc;
   ovm_pkg::angle_type yaw_in, pit_in, yaw_s1_ff, pit_s1_ff;

   always_comb begin
      ym = 17'(req_yaw_deg);
      if (ym < -ovm_pkg::FULL_TURN)  ym = ym + (ovm_pkg::FULL_TURN <<< 1);
      else if (ym < 0)               ym = ym + ovm_pkg::FULL_TURN;
      else if (ym >= ovm_pkg::FULL_TURN) ym = ym - ovm_pkg::FULL_TURN;
      if (ym >= ovm_pkg::HALF_TURN)  ym = ym - ovm_pkg::FULL_TURN;
      pc = 16'(req_pitch_deg);
      if (pc > ovm_pkg::QUARTER_TURN)  pc = ovm_pkg::QUARTER_TURN;
      if (pc < -ovm_pkg::QUARTER_TURN) pc = -ovm_pkg::QUARTER_TURN;
      yaw_in = ovm_pkg::fold_angle(16'(ym));
      pit_in = ovm_pkg::fold_angle(pc);
   end

   // ---------------- stage 2: quotient by 45 through a reciprocal
   ovm_pkg::angle_type yaw_s2_ff, pit_s2_ff;
   logic [25:0] yq_in, pq_in, yq_s2_ff, pq_s2_ff;

   assign yq_in = {13'd0, yaw_s1_ff.mag} * {13'd0, ovm_pkg::RECIP_45};
   assign pq_in = {13'd0, pit_s1_ff.mag} * {13'd0, ovm_pkg::RECIP_45};

   // ---------------- stage 3: binary angle = q * 2^23 + table(remainder)
   // constant table of the rounded fraction, built at elaboration
   logic [22:0] frac_tab [64];

   for (genvar g = 0; g < 64; g++) begin : g_frac
      localparam logic [22:0] FRAC_G = ovm_pkg::frac_lut(6'(g));
      assign frac_tab[g] = FRAC_G;
   end

   function automatic logic signed [33:0] to_bam(input ovm_pkg::angle_type a,
                                                 input logic [25:0] p);
      logic [7:0]         q;
      logic [5:0]         ra;
      logic [30:0]        mag;
      logic signed [33:0] zm;
      q   = p[25:18];
      ra  = 6'(a.mag - 13'({5'd0, q} * 13'd45));
      mag = {q, 23'd0} + {8'd0, frac_tab[ra]};
      zm  = $signed({3'd0, mag});
      return a.neg ? -zm : zm;
   endfunction

   logic signed [33:0] yz_s3_ff, pz_s3_ff;
   logic               yf_s3_ff, pf_s3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_s1_ff <= yaw_in;
         pit_s1_ff <= pit_in;
         yaw_s2_ff <= yaw_s1_ff;
         pit_s2_ff <= pit_s1_ff;
         yq_s2_ff  <= yq_in;
         pq_s2_ff  <= pq_in;
         yz_s3_ff  <= to_bam(yaw_s2_ff, yq_s2_ff);
         pz_s3_ff  <= to_bam(pit_s2_ff, pq_s2_ff);
         yf_s3_ff  <= yaw_s2_ff.flip;
         pf_s3_ff  <= pit_s2_ff.flip;
      end
   end

   // ---------------- CORDIC lanes
   ovm_pkg::cordic_ctl_type yctl, pctl;
   logic signed [31:0] cy, sy, cp, sp;

   assign yctl = '{en: adv, flip: yf_s3_ff};
   assign pctl = '{en: adv, flip: pf_s3_ff};

   ovm_cordic #(.ITER(TRIG_ITERATIONS)) u_yaw (
      .clock(clock), .ctl_i(yctl), .z_i(yz_s3_ff), .cos_o(cy), .sin_o(sy)
   );
   ovm_cordic #(.ITER(TRIG_ITERATIONS)) u_pitch (
      .clock(clock), .ctl_i(pctl), .z_i(pz_s3_ff), .cos_o(cp), .sin_o(sp)
   );

   // ---------------- stage 5: rotation part, entry index r*3+c
   function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return 32'((p + 64'sd536870912) >>> 30);
   endfunction

   logic signed [31:0] rm_ff [9];

   // ---------------- stage 6: target products and Q16.16 rotation entries
   logic signed [63:0] prod_ff [9];
   logic signed [31:0] rot6_ff [9];
   logic signed [31:0] rot7_ff [9];
   logic signed [31:0] rot8_ff [9];
   logic signed [32:0] rr [9];

   always_comb begin
      for (int k = 0; k < 9; k++) rr[k] = 33'(rm_ff[k]) + 33'sd8192;
   end

   // ---------------- stage 7: row sums; stage 8: round, negate, subtract distance, saturate
   logic signed [65:0] acc_ff [3];
   logic signed [31:0] tcol_ff [3];
   logic signed [31:0] tcol_in [3];

   always_comb begin
      logic signed [65:0] ar;
      logic signed [37:0] tr;
      for (int r = 0; r < 3; r++) begin
         ar = (acc_ff[r] + 66'sd536870912) >>> 30;
         tr = -$signed(ar[37:0]);
         if (r == 2) tr = tr - 38'(dist_ff[NV-2]);
         if (tr > 38'sd2147483647)       tcol_in[r] = 32'sh7fffffff;
         else if (tr < -38'sd2147483648) tcol_in[r] = 32'sh80000000;
         else                            tcol_in[r] = 32'(tr);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rm_ff[0] <= cy;
         rm_ff[1] <= '0;
         rm_ff[2] <= -sy;
         rm_ff[3] <= mul30(sp, sy);
         rm_ff[4] <= cp;
         rm_ff[5] <= mul30(sp, cy);
         rm_ff[6] <= mul30(cp, sy);
         rm_ff[7] <= -sp;
         rm_ff[8] <= mul30(cp, cy);
         for (int k = 0; k < 9; k++) begin
            prod_ff[k] <= 64'(rm_ff[k]) * 64'(tgt_ff[k % 3]);
            rot6_ff[k] <= 32'(rr[k] >>> 14);
            rot7_ff[k] <= rot6_ff[k];
            rot8_ff[k] <= rot7_ff[k];
         end
         for (int r = 0; r < 3; r++) begin
            acc_ff[r]  <= 66'(prod_ff[3*r]) + 66'(prod_ff[3*r+1]) + 66'(prod_ff[3*r+2]);
            tcol_ff[r] <= tcol_in[r];
         end
      end
   end

   // ---------------- matrix bank and response port
   logic signed [31:0] mat_ff [16];

   always_ff @(posedge clock) begin
      if (load) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) mat_ff[4*r+c] <= rot8_ff[3*r+c];
            mat_ff[4*r+3] <= tcol_ff[r];
         end
         mat_ff[12] <= '0;
         mat_ff[13] <= '0;
         mat_ff[14] <= '0;
         mat_ff[15] <= ovm_pkg::ONE_Q16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (rsp_valid_ff && rsp_ready) begin
         if (idx_ff == 4'd15) rsp_valid_ff <= 1'b0;
         else                 idx_ff       <= idx_ff + 4'd1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = idx_ff[3:2];
   assign rsp_col   = idx_ff[1:0];
   assign rsp_value = mat_ff[idx_ff];
   assign rsp_last  = idx_ff == 4'd15;

   // ---------------- assertions
   a_load_only_after_last : assert property (@(posedge clock) disable iff (reset)
      load && rsp_valid_ff |-> rsp_ready && idx_ff == 4'd15)
      else $error("matrix bank reloaded before its last word was taken");

   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_last_is_one : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_value == ovm_pkg::ONE_Q16)
      else $error("last word is not the unit corner entry");

   a_cordic_valid_flows : assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[S4] |=> vld_ff[S4+1])
      else $error("CORDIC result lost on its way to the products");

endmodule
